FILE: hw/rtl/cfr_pkg.sv
// ----------------------------------------------------------------------------
// cfr_pkg
// Shared types, codes and the CRC16 byte step for the command framer.
// ----------------------------------------------------------------------------
package cfr_pkg;

   // Request command codes (req_tuser)
   localparam logic [1:0] CMD_SEND = 2'd0;
   localparam logic [1:0] CMD_RX   = 2'd1;
   localparam logic [1:0] CMD_TICK = 2'd2;

   // Completion status codes
   localparam logic [1:0] STATUS_ACK     = 2'd0;
   localparam logic [1:0] STATUS_RETRIES = 2'd1;
   localparam logic [1:0] STATUS_TIMEOUT = 2'd2;
   localparam logic [1:0] STATUS_BUSY    = 2'd3;

   // Result kinds (rsp_tuser)
   localparam logic KIND_BYTE   = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   // Configuration register indexes
   localparam logic [1:0] CSR_MAX_RETRIES   = 2'd0;
   localparam logic [1:0] CSR_TIMEOUT_TICKS = 2'd1;
   localparam logic [1:0] CSR_ACK_VALUE     = 2'd2;

   // Configuration reset values
   localparam logic [3:0]  MAX_RETRIES_RST   = 4'd3;
   localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd1000;
   localparam logic [7:0]  ACK_VALUE_RST     = 8'hFF;

   // Value clamp on the limited command
   localparam logic [7:0] CLAMP_OPCODE = 8'd12;
   localparam logic [7:0] CLAMP_MAX    = 8'd127;

   // CRC16 (poly 0x1021, MSB first)
   localparam logic [15:0] CRC_POLY = 16'h1021;
   localparam logic [15:0] CRC_INIT = 16'h0000;
   localparam logic [15:0] TICK_MAX = 16'hFFFF;

   // Frame byte positions
   localparam logic [2:0] POS_ADDR   = 3'd0;
   localparam logic [2:0] POS_OPCODE = 3'd1;
   localparam logic [2:0] POS_VALUE  = 3'd2;
   localparam logic [2:0] POS_CRC_HI = 3'd3;
   localparam logic [2:0] POS_CRC_LO = 3'd4;

   // Work handed from the exchange control to the frame transmitter
   typedef struct packed {
      logic       valid;
      logic       is_status;
      logic [1:0] status;
      logic [7:0] address;
      logic [7:0] opcode;
      logic [7:0] value;
   } cfr_job_type;

   // One byte folded into the CRC, eight shift steps
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {data, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

FILE: hw/rtl/cfr_ctrl.sv
// ----------------------------------------------------------------------------
// cfr_ctrl
// Request register, configuration registers and the exchange state: decides
// per request whether a frame, a status or nothing goes to the transmitter.
// ----------------------------------------------------------------------------
module cfr_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [31:0]          req_tdata,   // dev_address, opcode, arg_value, rx_byte
   input  logic [1:0]           req_tuser,   // cmd
   // configuration write channel
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [1:0]           csr_index,
   input  logic [15:0]          csr_data,
   // job to the transmitter
   output cfr_pkg::cfr_job_type job,
   input  logic                 job_ready
);
   import cfr_pkg::*;

   // request register
   logic        in_valid_ff, in_valid_in;
   logic [1:0]  in_cmd_ff,   in_cmd_in;
   logic [7:0]  in_addr_ff,  in_addr_in;
   logic [7:0]  in_op_ff,    in_op_in;
   logic [7:0]  in_val_ff,   in_val_in;
   logic [7:0]  in_rx_ff,    in_rx_in;

   // configuration
   logic [3:0]  max_retries_ff,   max_retries_in;
   logic [15:0] timeout_ticks_ff, timeout_ticks_in;
   logic [7:0]  ack_value_ff,     ack_value_in;

   // exchange state
   logic        busy_ff,  busy_in;
   logic [7:0]  held_addr_ff, held_addr_in;
   logic [7:0]  held_op_ff,   held_op_in;
   logic [7:0]  held_val_ff,  held_val_in;
   logic [3:0]  tries_ff, tries_in;
   logic [15:0] tick_ff,  tick_in;

   logic        req_xfer;
   logic        consume;
   logic [7:0]  clamped_val;
   logic [15:0] tick_inc;

   assign req_xfer   = req_tvalid && req_tready;
   assign consume    = in_valid_ff && (!job.valid || job_ready);
   assign req_tready = !in_valid_ff || consume;
   assign csr_ready  = 1'b1;

   assign clamped_val = (in_op_ff == CLAMP_OPCODE && in_val_ff > CLAMP_MAX) ? CLAMP_MAX
                                                                            : in_val_ff;
   assign tick_inc    = (tick_ff < TICK_MAX) ? tick_ff + 16'd1 : tick_ff;

   // request register next value
   always_comb begin
      in_valid_in = in_valid_ff;
      in_cmd_in   = in_cmd_ff;
      in_addr_in  = in_addr_ff;
      in_op_in    = in_op_ff;
      in_val_in   = in_val_ff;
      in_rx_in    = in_rx_ff;
      if (req_xfer) begin
         in_valid_in = 1'b1;
         in_cmd_in   = req_tuser;
         in_addr_in  = req_tdata[7:0];
         in_op_in    = req_tdata[15:8];
         in_val_in   = req_tdata[23:16];
         in_rx_in    = req_tdata[31:24];
      end else if (consume) begin
         in_valid_in = 1'b0;
      end
   end

   // configuration writes; indexes past the list are dropped
   always_comb begin
      max_retries_in   = max_retries_ff;
      timeout_ticks_in = timeout_ticks_ff;
      ack_value_in     = ack_value_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MAX_RETRIES:   max_retries_in   = csr_data[3:0];
            CSR_TIMEOUT_TICKS: timeout_ticks_in = csr_data;
            CSR_ACK_VALUE:     ack_value_in     = csr_data[7:0];
            default: ;
         endcase
      end
   end

   // exchange decision for the item in the request register
   always_comb begin
      job           = '0;
      job.address   = held_addr_ff;
      job.opcode    = held_op_ff;
      job.value     = held_val_ff;
      busy_in       = busy_ff;
      held_addr_in  = held_addr_ff;
      held_op_in    = held_op_ff;
      held_val_in   = held_val_ff;
      tries_in      = tries_ff;
      tick_in       = tick_ff;
      unique case (in_cmd_ff)
         CMD_SEND: begin
            job.valid = in_valid_ff;
            if (busy_ff) begin
               job.is_status = 1'b1;
               job.status    = STATUS_BUSY;
            end else begin
               job.address  = in_addr_ff;
               job.opcode   = in_op_ff;
               job.value    = clamped_val;
               held_addr_in = in_addr_ff;
               held_op_in   = in_op_ff;
               held_val_in  = clamped_val;
               tries_in     = max_retries_ff;
               tick_in      = '0;
               busy_in      = 1'b1;
            end
         end
         CMD_RX: begin
            if (busy_ff) begin
               job.valid = in_valid_ff;
               tick_in   = '0;
               priority if (in_rx_ff == ack_value_ff) begin
                  job.is_status = 1'b1;
                  job.status    = STATUS_ACK;
                  busy_in       = 1'b0;
               end else if (tries_ff != 4'd0) begin
                  tries_in = tries_ff - 4'd1;
               end else begin
                  job.is_status = 1'b1;
                  job.status    = STATUS_RETRIES;
                  busy_in       = 1'b0;
               end
            end
         end
         CMD_TICK: begin
            if (busy_ff) begin
               tick_in = tick_inc;
               if (tick_inc >= timeout_ticks_ff) begin
                  job.valid     = in_valid_ff;
                  job.is_status = 1'b1;
                  job.status    = STATUS_TIMEOUT;
                  busy_in       = 1'b0;
               end
            end
         end
         default: ;
      endcase
   end

   // registers
   always_ff @(posedge clock) begin
      in_cmd_ff  <= in_cmd_in;
      in_addr_ff <= in_addr_in;
      in_op_ff   <= in_op_in;
      in_val_ff  <= in_val_in;
      in_rx_ff   <= in_rx_in;
      if (reset) begin
         in_valid_ff      <= 1'b0;
         max_retries_ff   <= MAX_RETRIES_RST;
         timeout_ticks_ff <= TIMEOUT_TICKS_RST;
         ack_value_ff     <= ACK_VALUE_RST;
         busy_ff          <= 1'b0;
         held_addr_ff     <= '0;
         held_op_ff       <= '0;
         held_val_ff      <= '0;
         tries_ff         <= '0;
         tick_ff          <= '0;
      end else begin
         in_valid_ff      <= in_valid_in;
         max_retries_ff   <= max_retries_in;
         timeout_ticks_ff <= timeout_ticks_in;
         ack_value_ff     <= ack_value_in;
         if (consume) begin
            busy_ff      <= busy_in;
            held_addr_ff <= held_addr_in;
            held_op_ff   <= held_op_in;
            held_val_ff  <= held_val_in;
            tries_ff     <= tries_in;
            tick_ff      <= tick_in;
         end
      end
   end

endmodule

FILE: hw/rtl/cfr_frame_tx.sv
// ----------------------------------------------------------------------------
// cfr_frame_tx
// Serializes a job into five frame bytes (payload, CRC high, CRC low) or a
// single status result, folding each payload byte into the CRC as it goes out.
// ----------------------------------------------------------------------------
module cfr_frame_tx (
   input  logic                 clock,
   input  logic                 reset,
   input  cfr_pkg::cfr_job_type job,
   output logic                 job_ready,
   // result channel
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [15:0]          rsp_tdata,   // tx_byte, status, zero pad
   output logic [0:0]           rsp_tuser,   // out_kind
   output logic                 rsp_tlast    // last
);
   import cfr_pkg::*;

   logic        active_ff, active_in;
   cfr_job_type job_ff,    job_in;
   logic [2:0]  pos_ff,    pos_in;
   logic [15:0] crc_ff,    crc_in;

   logic        rsp_valid_ff,  rsp_valid_in;
   logic        rsp_kind_ff,   rsp_kind_in;
   logic [7:0]  rsp_byte_ff,   rsp_byte_in;
   logic        rsp_last_ff,   rsp_last_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;

   logic        out_free;
   logic        emit;
   logic        last_emit;
   logic        take_job;
   logic [7:0]  frame_byte;
   logic [15:0] crc_base;

   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign emit      = active_ff && out_free;
   assign last_emit = emit && (job_ff.is_status || pos_ff == POS_CRC_LO);
   assign job_ready = !active_ff || last_emit;
   assign take_job  = job.valid && job_ready;
   assign crc_base  = (pos_ff == POS_ADDR) ? CRC_INIT : crc_ff;

   // byte at the current frame position
   always_comb begin
      unique case (pos_ff)
         POS_ADDR:   frame_byte = job_ff.address;
         POS_OPCODE: frame_byte = job_ff.opcode;
         POS_VALUE:  frame_byte = job_ff.value;
         POS_CRC_HI: frame_byte = crc_ff[15:8];
         POS_CRC_LO: frame_byte = crc_ff[7:0];
         default:    frame_byte = '0;
      endcase
   end

   // sequencing and CRC accumulation
   always_comb begin
      active_in = active_ff;
      job_in    = job_ff;
      pos_in    = pos_ff;
      crc_in    = crc_ff;
      if (emit && !job_ff.is_status && pos_ff <= POS_VALUE) begin
         crc_in = crc_byte(crc_base, frame_byte);
      end
      if (take_job) begin
         active_in = 1'b1;
         job_in    = job;
         pos_in    = POS_ADDR;
      end else if (last_emit) begin
         active_in = 1'b0;
      end else if (emit) begin
         pos_in = pos_ff + 3'd1;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_byte_in   = rsp_byte_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_status_in = rsp_status_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         if (job_ff.is_status) begin
            rsp_kind_in   = KIND_STATUS;
            rsp_byte_in   = '0;
            rsp_last_in   = 1'b1;
            rsp_status_in = job_ff.status;
         end else begin
            rsp_kind_in   = KIND_BYTE;
            rsp_byte_in   = frame_byte;
            rsp_last_in   = (pos_ff == POS_CRC_LO);
            rsp_status_in = STATUS_ACK;
         end
      end
   end

   always_ff @(posedge clock) begin
      job_ff        <= job_in;
      crc_ff        <= crc_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
      if (reset) begin
         active_ff    <= 1'b0;
         pos_ff       <= POS_ADDR;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_status_ff, rsp_byte_ff};
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

FILE: hw/rtl/crc16_command_framer_with_retry.sv
// ----------------------------------------------------------------------------
// crc16_command_framer_with_retry
// Host side of a packet link: frames send requests with a CRC16, resends on
// a negative answer, and reports acknowledge, failure, timeout or busy.
// Path: request register, transmitter job register, output register.
// Throughput: one request per cycle unless a pending job waits for the
// transmitter; a send or resend gives one result per frame byte, a status one.
// Reset clears the exchange state and restores the configuration defaults
// (max_retries 3, timeout_ticks 1000, ack_value 0xFF).
// ----------------------------------------------------------------------------
module crc16_command_framer_with_retry (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // dev_address, opcode, arg_value, rx_byte
   input  logic [1:0]  req_tuser,   // cmd
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // tx_byte, status, zero pad
   output logic [0:0]  rsp_tuser,   // out_kind
   output logic        rsp_tlast,   // last
   // configuration write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
   import cfr_pkg::*;

   cfr_job_type job;
   logic        job_ready;

   cfr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .job        (job),
      .job_ready  (job_ready)
   );

   cfr_frame_tx u_frame_tx (
      .clock      (clock),
      .reset      (reset),
      .job        (job),
      .job_ready  (job_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // a status result always closes its run
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0] == KIND_STATUS) |-> rsp_tlast)
      else $error("status result without last");

   // a status result carries no transmit byte
   a_status_zero_byte: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0] == KIND_STATUS) |-> rsp_tdata[7:0] == 8'd0)
      else $error("status result with nonzero byte");

   // a frame byte carries a zero status field
   a_byte_zero_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0] == KIND_BYTE) |-> rsp_tdata[9:8] == STATUS_ACK)
      else $error("frame byte with nonzero status");

   // no result is presented right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

FILE: sim/framer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framer_checker
// Watches the request, result and register channels of the command framer.
// Keeps its own copy of the exchange state and the registers, works out the
// bytes and status each request transfer should produce, and compares every
// result transfer with the oldest outstanding expectation.
// ----------------------------------------------------------------------------
module framer_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,   // dev_address, opcode, arg_value, rx_byte
   input  logic [1:0]  req_tuser,   // cmd
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,   // tx_byte, status, zero pad
   input  logic [0:0]  rsp_tuser,   // out_kind
   input  logic        rsp_tlast,   // last
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data,
   output int unsigned mismatches,
   output int unsigned outstanding,
   output logic        link_busy,
   output int unsigned live_items
);
   import cfr_pkg::*;

   // One result as it leaves the block
   typedef struct packed {
      logic       kind;
      logic [7:0] tx_byte;
      logic       last;
      logic [1:0] status;
   } framer_out_type;

   framer_out_type expected_out[$];

   // Register copies
   logic [3:0]  cfg_retries;
   logic [15:0] cfg_timeout;
   logic [7:0]  cfg_ack;

   // Exchange state
   logic        in_exchange;
   logic [7:0]  frame_addr;
   logic [7:0]  frame_opcode;
   logic [7:0]  frame_value;
   logic [3:0]  retries_left;
   logic [15:0] ticks_waited;

   int unsigned err_count;
   int unsigned live_count;

   // CRC16 over the three payload bytes, one bit at a time, MSB first
   function automatic logic [15:0] frame_crc(input logic [23:0] payload);
      logic [15:0] acc;
      logic        feedback;
      acc = CRC_INIT;
      for (int b = 23; b >= 0; b--) begin
         feedback = acc[15] ^ payload[b];
         acc      = {acc[14:0], 1'b0};
         if (feedback) begin
            acc = acc ^ CRC_POLY;
         end
      end
      return acc;
   endfunction

   task automatic push_result(input logic kind, input logic [7:0] tx_byte,
                              input logic last, input logic [1:0] status);
      framer_out_type item;
      item.kind    = kind;
      item.tx_byte = tx_byte;
      item.last    = last;
      item.status  = status;
      expected_out.push_back(item);
   endtask

   task automatic push_frame();
      logic [15:0] crc;
      crc = frame_crc({frame_addr, frame_opcode, frame_value});
      push_result(KIND_BYTE, frame_addr, 1'b0, STATUS_ACK);
      push_result(KIND_BYTE, frame_opcode, 1'b0, STATUS_ACK);
      push_result(KIND_BYTE, frame_value, 1'b0, STATUS_ACK);
      push_result(KIND_BYTE, crc[15:8], 1'b0, STATUS_ACK);
      push_result(KIND_BYTE, crc[7:0], 1'b1, STATUS_ACK);
   endtask

   task automatic end_exchange(input logic [1:0] status);
      in_exchange = 1'b0;
      push_result(KIND_STATUS, 8'h00, 1'b1, status);
   endtask

   // Effect of one request transfer on the exchange
   task automatic take_request(input logic [1:0] cmd, input logic [31:0] word);
      if (cmd == CMD_SEND) begin
         live_count++;
         if (in_exchange) begin
            // rejected, exchange in progress continues
            push_result(KIND_STATUS, 8'h00, 1'b1, STATUS_BUSY);
         end else begin
            frame_addr   = word[7:0];
            frame_opcode = word[15:8];
            frame_value  = word[23:16];
            if (frame_opcode == CLAMP_OPCODE && frame_value > CLAMP_MAX) begin
               frame_value = CLAMP_MAX;
            end
            retries_left = cfg_retries;
            ticks_waited = '0;
            in_exchange  = 1'b1;
            push_frame();
         end
      end else if (in_exchange && cmd == CMD_RX) begin
         live_count++;
         ticks_waited = '0;
         if (word[31:24] == cfg_ack) begin
            end_exchange(STATUS_ACK);
         end else if (retries_left != 0) begin
            retries_left = retries_left - 4'd1;
            push_frame();
         end else begin
            end_exchange(STATUS_RETRIES);
         end
      end else if (in_exchange && cmd == CMD_TICK) begin
         live_count++;
         if (ticks_waited != TICK_MAX) begin
            ticks_waited = ticks_waited + 16'd1;
         end
         if (ticks_waited >= cfg_timeout) begin
            end_exchange(STATUS_TIMEOUT);
         end
      end
   endtask

   // Register writes, request prediction and result compare on each edge
   always @(posedge clock) begin : watch
      framer_out_type got;
      framer_out_type want;
      if (reset) begin
         cfg_retries  = MAX_RETRIES_RST;
         cfg_timeout  = TIMEOUT_TICKS_RST;
         cfg_ack      = ACK_VALUE_RST;
         in_exchange  = 1'b0;
         frame_addr   = '0;
         frame_opcode = '0;
         frame_value  = '0;
         retries_left = '0;
         ticks_waited = '0;
         expected_out.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MAX_RETRIES:   cfg_retries = csr_data[3:0];
               CSR_TIMEOUT_TICKS: cfg_timeout = csr_data;
               CSR_ACK_VALUE:     cfg_ack     = csr_data[7:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            take_request(req_tuser, req_tdata);
         end
         if (rsp_tvalid && rsp_tready) begin
            got.kind    = rsp_tuser[0];
            got.tx_byte = rsp_tdata[7:0];
            got.last    = rsp_tlast;
            got.status  = rsp_tdata[9:8];
            if (expected_out.size() == 0) begin
               if (err_count < 10) begin
                  $display("unexpected result: kind %0d byte %02h last %0d status %0d",
                           got.kind, got.tx_byte, got.last, got.status);
               end
               err_count++;
            end else begin
               want = expected_out.pop_front();
               if (got != want) begin
                  if (err_count < 10) begin
                     $display("result mismatch: expected kind %0d byte %02h last %0d status %0d",
                              want.kind, want.tx_byte, want.last, want.status);
                     $display("                 got kind %0d byte %02h last %0d status %0d",
                              got.kind, got.tx_byte, got.last, got.status);
                  end
                  err_count++;
               end
            end
         end
      end
      mismatches  <= err_count;
      outstanding <= expected_out.size();
      link_busy   <= in_exchange;
      live_items  <= live_count;
   end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the command framer with directed and random exchanges (sends,
// negative and positive answers, ticks, busy rejects and stray codes) under
// several register settings, with bursty requests and a stalling result
// side; the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
   import cfr_pkg::*;

   localparam logic [1:0] CMD_UNUSED = 2'd3;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 8;
   localparam int RANDOM_ITEMS  = 500;
   localparam int PHASES        = 8;

   // Result-side stall modes
   localparam int STALL_NONE   = 0;
   localparam int STALL_COIN   = 1;
   localparam int STALL_SPARSE = 2;
   localparam int STALL_LIGHT  = 3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;    // dev_address, opcode, arg_value, rx_byte
   logic [1:0]  req_tuser = CMD_TICK; // cmd
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;        // tx_byte, status, zero pad
   logic [0:0]  rsp_tuser;        // out_kind
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = CSR_MAX_RETRIES;
   logic [15:0] csr_data = '0;

   int unsigned mismatches;
   int unsigned outstanding;
   int unsigned live_items;
   logic        link_busy;

   int unsigned cycle_count = 0;
   int          burst_left = 0;
   logic [7:0]  stall_tick = '0;
   int          stall_mode = STALL_NONE;

   // Register values currently written into the block
   logic [3:0]  cfg_retries_now = MAX_RETRIES_RST;
   logic [15:0] cfg_timeout_now = TIMEOUT_TICKS_RST;
   logic [7:0]  cfg_ack_now = ACK_VALUE_RST;

   crc16_command_framer_with_retry u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   framer_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .mismatches  (mismatches),
      .outstanding (outstanding),
      .link_busy   (link_busy),
      .live_items  (live_items)
   );

   // Clock and reset
   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("testbench: FAIL");
      $finish;
   end

   // Result-side backpressure; the mode is redrawn whenever the low six bits of stall_tick are zero
   always @(posedge clock) begin
      stall_tick <= stall_tick + 8'd1;
      if (stall_tick[5:0] == 6'd0) begin
         stall_mode <= $urandom_range(STALL_NONE, STALL_LIGHT);
      end
      case (stall_mode)
         STALL_NONE:   rsp_tready <= 1'b1;
         STALL_COIN:   rsp_tready <= 1'($urandom_range(0, 1));
         STALL_SPARSE: rsp_tready <= (stall_tick[1:0] == 2'd3);
         default:      rsp_tready <= ($urandom_range(0, 7) != 0);
      endcase
   end

   // One request transfer; bursts of random length with random gaps between
   task automatic put_request(input logic [1:0] cmd, input logic [31:0] word);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= word;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic do_send(input logic [7:0] addr, input logic [7:0] opcode,
                          input logic [7:0] value);
      put_request(CMD_SEND, {8'($urandom_range(0, 255)), value, opcode, addr});
   endtask

   task automatic do_answer(input logic [7:0] rx);
      put_request(CMD_RX, {rx, 8'($urandom_range(0, 255)), 16'($urandom())});
   endtask

   // Hold requests until every expected result has come, then let it settle
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Close any open exchange so registers can be written
   task automatic settle_idle();
      wait_drained();
      if (link_busy) begin
         do_answer(cfg_ack_now);
         wait_drained();
      end
   endtask

   task automatic write_config(input logic [3:0] retries, input logic [15:0] ticks,
                               input logic [7:0] ack);
      csr_valid <= 1'b1;
      csr_index <= CSR_MAX_RETRIES;
      csr_data  <= {12'd0, retries};
      do @(posedge clock); while (!csr_ready);
      csr_index <= CSR_TIMEOUT_TICKS;
      csr_data  <= ticks;
      do @(posedge clock); while (!csr_ready);
      csr_index <= CSR_ACK_VALUE;
      csr_data  <= {8'd0, ack};
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      cfg_retries_now = retries;
      cfg_timeout_now = ticks;
      cfg_ack_now     = ack;
   endtask

   // Stimulus and verdict
   initial begin
      int unsigned goal;
      int          n_nack;
      int          noise_len;
      logic [7:0]  nack;
      logic [7:0]  opcode;
      logic [15:0] retries_pick;
      logic [15:0] timeout_pick;
      logic [7:0]  ack_pick;

      wait (reset == 1'b0);
      @(posedge clock);

      // Directed: ignored items while idle, reset register values
      do_answer(8'h55);
      put_request(CMD_TICK, 32'hFFFF_FFFF);
      put_request(CMD_UNUSED, 32'h0000_0000);
      // all-zero frame, stray code and busy reject mid-exchange, resend, ack
      do_send(8'h00, 8'h00, 8'h00);
      put_request(CMD_UNUSED, 32'hFFFF_FFFF);
      do_send(8'h11, 8'h22, 8'h33);
      do_answer(8'h00);
      put_request(CMD_TICK, 32'h0);
      do_answer(8'hFF);
      // clamp of the limited command, retries used up
      do_send(8'hFF, CLAMP_OPCODE, 8'hFF);
      repeat (4) do_answer(8'h7E);
      // clamp boundary both sides, all-ones frame
      do_send(8'hA5, CLAMP_OPCODE, 8'h80);
      do_answer(8'hFF);
      do_send(8'h5A, CLAMP_OPCODE, 8'h7F);
      do_answer(8'hFF);
      do_send(8'hFF, 8'hFF, 8'hFF);
      do_answer(8'hFF);

      // Zero timeout ends the exchange on the first tick
      settle_idle();
      write_config(4'd0, 16'd0, 8'h00);
      do_send(8'h01, 8'h02, 8'h03);
      put_request(CMD_TICK, 32'h0);

      // An answer restarts the tick count for the resend
      settle_idle();
      write_config(4'd15, 16'd2, 8'h5A);
      do_send(8'h80, 8'h0C, 8'hC0);
      put_request(CMD_TICK, 32'h0);
      do_answer(8'h00);
      put_request(CMD_TICK, 32'h0);
      put_request(CMD_TICK, 32'h0);
      do_send(8'h7F, 8'h40, 8'h01);
      do_answer(8'h5A);

      // Random phases, register extremes first
      for (int phase = 0; phase < PHASES; phase++) begin
         settle_idle();
         retries_pick = (phase == 0) ? 16'd0 : (phase == 1) ? 16'd15
                                                            : 16'($urandom_range(0, 15));
         if (phase == 0) begin
            timeout_pick = 16'd1;
         end else if (phase == 1) begin
            timeout_pick = 16'hFFFF;
         end else if (phase % 2 == 0) begin
            timeout_pick = 16'($urandom_range(1, 12));
         end else begin
            timeout_pick = 16'($urandom_range(1, 65535));
         end
         ack_pick = (phase == 0) ? 8'h00 : (phase == 1) ? 8'hFF
                                                        : 8'($urandom_range(0, 255));
         write_config(retries_pick[3:0], timeout_pick, ack_pick);

         goal = live_items + RANDOM_ITEMS / PHASES;
         while (live_items < goal) begin
            if ($urandom_range(0, 6) == 0) begin
               // noise: any code, any content
               noise_len = $urandom_range(1, 6);
               repeat (noise_len) put_request(2'($urandom_range(0, 3)), $urandom());
            end else begin
               // well-formed exchange with random content
               opcode = ($urandom_range(0, 3) == 0) ? CLAMP_OPCODE
                                                    : 8'($urandom_range(0, 255));
               do_send(8'($urandom_range(0, 255)), opcode, 8'($urandom_range(0, 255)));
               n_nack = $urandom_range(0, cfg_retries_now + 1);
               for (int k = 0; k < n_nack; k++) begin
                  if ($urandom_range(0, 3) == 0) begin
                     put_request(CMD_TICK, $urandom());
                  end
                  if ($urandom_range(0, 11) == 0) begin
                     put_request(CMD_SEND, $urandom());
                  end
                  if ($urandom_range(0, 19) == 0) begin
                     put_request(CMD_UNUSED, $urandom());
                  end
                  nack = 8'($urandom_range(0, 255));
                  if (nack == cfg_ack_now) begin
                     nack = nack ^ 8'h01;
                  end
                  do_answer(nack);
               end
               if (n_nack <= cfg_retries_now) begin
                  if (cfg_timeout_now <= 16 && $urandom_range(0, 1) == 1) begin
                     repeat (cfg_timeout_now) put_request(CMD_TICK, $urandom());
                  end else begin
                     do_answer(cfg_ack_now);
                  end
               end
            end
            // occasional full pause until the result side has caught up
            if ($urandom_range(0, 29) == 0) begin
               wait_drained();
            end
         end
      end

      wait_drained();
      if (mismatches == 0 && outstanding == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule
